[rtl/musical_scale_note_snapper_unit_macros.svh]
// Assertion macros shared by the note snapper RTL.
// Each macro checks a property on the rising clock edge and is disabled in reset.
`ifndef MUSICAL_SCALE_NOTE_SNAPPER_UNIT_MACROS_SVH
`define MUSICAL_SCALE_NOTE_SNAPPER_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define MSNS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("msns assertion failed");

// Next-cycle implication.
`define MSNS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("msns assertion failed");

`else

`define MSNS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MSNS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/msns_pkg.sv]
package msns_pkg;

    // Field widths.
    localparam int NOTE_IN_W  = 9;
    localparam int NOTE_W     = 7;
    localparam int ROOT_W     = 4;
    localparam int KIND_W     = 3;
    localparam int PC_W       = 4;
    localparam int OCTAVE     = 12;
    localparam int SEARCH_SPAN = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROOT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KIND = 1'd1;

    // Scale kind codes.
    localparam logic [KIND_W-1:0] KIND_MAJOR      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MINOR      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DORIAN     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_MIXOLYDIAN = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CHROMATIC  = 3'd4;

    typedef logic signed [NOTE_IN_W-1:0] note_in_t;
    typedef logic [NOTE_W-1:0]           note_t;
    typedef logic [ROOT_W-1:0]           root_t;
    typedef logic [KIND_W-1:0]           kind_t;
    typedef logic [OCTAVE-1:0]           pc_mask_t;

    // Active scale as seen by the snapping logic.
    typedef struct packed {
        pc_mask_t mask;
        kind_t    kind;
    } cfg_state_t;

    // Result of one snap.
    typedef struct packed {
        note_t clamped;
        note_t snapped;
        logic  hit;
    } snap_result_t;

    // Interval mask of each scale kind: bit k set when k semitones above the root is in the scale.
    function automatic pc_mask_t kind_mask(input kind_t kind);
        pc_mask_t m;
        case (kind)
            KIND_MAJOR:      m = 12'h AB5;
            KIND_MINOR:      m = 12'h5AD;
            KIND_DORIAN:     m = 12'h6AD;
            KIND_MIXOLYDIAN: m = 12'h6B5;
            KIND_CHROMATIC:  m = 12'hFFF;
            default:         m = 12'h000;
        endcase
        return m;
    endfunction

endpackage

[rtl/msns_if.sv]
// Note input channel.
interface msns_note_if;
    logic               valid;
    logic               ready;
    msns_pkg::note_in_t note_in;

    modport source (output valid, output note_in, input ready);
    modport sink (input valid, input note_in, output ready);
endinterface

// Snapped note result channel.
interface msns_result_if;
    logic            valid;
    logic            ready;
    msns_pkg::note_t snapped_note;
    logic            was_in_scale;

    modport source (output valid, output snapped_note, output was_in_scale, input ready);
    modport sink (input valid, input snapped_note, input was_in_scale, output ready);
endinterface

// Configuration write channel.
interface msns_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [msns_pkg::CFG_IDX_W-1:0]      reg_index;
    logic [msns_pkg::CFG_DATA_W-1:0]     wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

[rtl/msns_cfg.sv]
module msns_cfg (
    input  logic                 clk,
    input  logic                 rst_n,
    msns_cfg_if.sink             cfg,
    output msns_pkg::cfg_state_t cfg_state
);
    import msns_pkg::*;

    root_t    root_reg;
    kind_t    kind_reg;
    root_t    root_red;
    pc_mask_t rel_mask;
    logic [2*OCTAVE-1:0] dbl_mask;
    logic [4:0]          rot_amt;

    // Writes are taken in any cycle.
    assign cfg.ready = 1'b1;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_reg <= '0;
            kind_reg <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_ROOT: root_reg <= cfg.wdata;
                REG_KIND: kind_reg <= cfg.wdata[KIND_W-1:0];
                default:  ;
            endcase
        end
    end

    // Rotate the interval mask by the root so that bit p stands for pitch class p.
    always_comb
    begin
        root_red = (root_reg >= ROOT_W'(OCTAVE)) ? root_reg - ROOT_W'(OCTAVE) : root_reg;
        rel_mask = kind_mask(kind_reg);
        dbl_mask = {rel_mask, rel_mask};
        rot_amt  = 5'(OCTAVE) - 5'(root_red);
    end

    assign cfg_state.mask = OCTAVE'(dbl_mask >> rot_amt);
    assign cfg_state.kind = kind_reg;

endmodule

[rtl/msns_core.sv]
module msns_core (
    input  msns_pkg::note_in_t     note_in,
    input  msns_pkg::cfg_state_t   cfg_state,
    output msns_pkg::snap_result_t snap
);
    import msns_pkg::*;

    note_t                    clamped;
    logic [12:0]              prod;
    logic [PC_W-1:0]          quot;
    note_t                    rem_full;
    logic [PC_W-1:0]          pc;
    logic [3*OCTAVE-1:0]      triple;
    logic [SEARCH_SPAN-1:0]   lo_ok;
    logic [SEARCH_SPAN-1:0]   up_ok;
    note_t                    cand;
    logic                     hit;
    logic                     found;

    // Saturate to the note range.
    always_comb
    begin
        if (note_in[NOTE_IN_W-1])
            clamped = '0;
        else if (note_in[NOTE_IN_W-2])
            clamped = NOTE_MAX;
        else
            clamped = note_in[NOTE_W-1:0];
    end

    // Pitch class by reciprocal multiplication; 43/512 is exact for notes up to 127.
    always_comb
    begin
        prod     = 13'(clamped) * 13'd43;
        quot     = prod[12:9];
        rem_full = clamped - (NOTE_W'(quot) * NOTE_W'(OCTAVE));
        pc       = rem_full[PC_W-1:0];
        hit      = cfg_state.mask[pc];
    end

    // Test every candidate at distances one to twelve in parallel.
    always_comb
    begin
        triple = {cfg_state.mask, cfg_state.mask, cfg_state.mask};
        for (int d = 1; d <= SEARCH_SPAN; d++)
        begin
            lo_ok[d-1] = (clamped >= NOTE_W'(d))
                && triple[6'(pc) + 6'(OCTAVE) - 6'(d)];
            up_ok[d-1] = ((8'(clamped) + 8'(d)) <= 8'(NOTE_MAX))
                && triple[6'(pc) + 6'(OCTAVE) + 6'(d)];
        end
    end

    // Nearest candidate wins; at equal distance the lower one wins.
    always_comb
    begin
        cand = clamped;
        for (int d = SEARCH_SPAN; d >= 1; d--)
        begin
            if (up_ok[d-1])
                cand = clamped + NOTE_W'(d);
            if (lo_ok[d-1])
                cand = clamped - NOTE_W'(d);
        end
        found = (|lo_ok) || (|up_ok);
    end

    assign snap.clamped = clamped;
    assign snap.snapped = (hit || !found) ? clamped : cand;
    assign snap.hit     = hit;

endmodule

[rtl/musical_scale_note_snapper_unit.sv]
// Each note passes the input register, then the snapping logic, then the output register.
// Throughput: one note per cycle unless the result stalls; the input register feeds the snapping logic directly.
// A stalled result holds in the output register while one more note waits in the input register.
// Reset (rst_n low, asynchronous) empties both stages and sets root and scale kind to zero.
module musical_scale_note_snapper_unit (
    input  logic          clk,
    input  logic          rst_n,
    msns_note_if.sink     note,
    msns_result_if.source result,
    msns_cfg_if.sink      cfg
);
    import msns_pkg::*;

    `include "musical_scale_note_snapper_unit_macros.svh"

    cfg_state_t   cfg_state;
    snap_result_t snap;

    logic     s1_valid_reg;
    logic     s1_valid_next;
    note_in_t s1_note_reg;
    logic     res_valid_reg;
    logic     res_valid_next;
    note_t    res_note_reg;
    logic     res_hit_reg;
    logic     res_load;

    // Configuration registers and scale mask.
    msns_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cfg_state (cfg_state)
    );

    // Snapping logic between the two registers.
    msns_core u_core (
        .note_in   (s1_note_reg),
        .cfg_state (cfg_state),
        .snap      (snap)
    );

    // Flow control: each stage advances when the one after it can take its transaction.
    assign res_load       = !res_valid_reg || result.ready;
    assign note.ready     = !s1_valid_reg || res_load;
    assign s1_valid_next  = note.ready ? note.valid : s1_valid_reg;
    assign res_valid_next = res_load ? s1_valid_reg : res_valid_reg;

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (note.valid && note.ready)
            s1_note_reg <= note.note_in;
        if (res_load && s1_valid_reg)
        begin
            res_note_reg <= snap.snapped;
            res_hit_reg  <= snap.hit;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.snapped_note = res_note_reg;
    assign result.was_in_scale = res_hit_reg;

    // A note already in the scale leaves unchanged.
    `MSNS_ASSERT_NXT(a_hit_unchanged, clk, rst_n, res_load && s1_valid_reg && snap.hit, res_note_reg == $past(snap.clamped))
    // A note held in the input stage is not dropped while the output stalls.
    `MSNS_ASSERT_NXT(a_s1_held, clk, rst_n, s1_valid_reg && !res_load, s1_valid_reg && $stable(s1_note_reg))
    // Pass-through kinds never report a note as in the scale.
    `MSNS_ASSERT_NXT(a_pass_no_hit, clk, rst_n, res_load && s1_valid_reg && cfg_state.kind > KIND_CHROMATIC, !res_hit_reg)
    // Chromatic scale reports every note as in the scale.
    `MSNS_ASSERT_NXT(a_chrom_hit, clk, rst_n, res_load && s1_valid_reg && cfg_state.kind == KIND_CHROMATIC, res_hit_reg)
    // The output stage only fills from a valid input stage.
    `MSNS_ASSERT_IMP(a_res_source, clk, rst_n, $rose(res_valid_reg), $past(s1_valid_reg))

endmodule
